// ----- design/bfca_pkg.sv -----
// bfca_pkg: shared types and constants of the barometer FIFO compensation block.
// Used by bfca_front, bfca_queue, bfca_back and the top level. No dependencies.
`default_nettype none
package bfca_pkg;

	// calibration image: NVM byte i at bits [8i+7:8i]
	localparam int CalBytes = 21;
	localparam int CalW     = 8 * CalBytes;

	// register map (index = paddr[4:3])
	localparam logic [1:0] REG_CAL_LOW  = 2'd0;
	localparam logic [1:0] REG_CAL_MID  = 2'd1;
	localparam logic [1:0] REG_CAL_HIGH = 2'd2;
	localparam logic [1:0] REG_FIRST    = 2'd3;

	// frame header decode
	localparam logic [1:0] HDR_SENSOR = 2'b10;
	localparam logic [3:0] FLD_TP     = 4'b0101;
	localparam logic [3:0] FLD_TIME   = 4'b1000;
	localparam logic [2:0] TP_LEN     = 3'd6;
	localparam logic [2:0] TIME_LEN   = 3'd3;
	localparam logic [2:0] CTRL_LEN   = 3'd1;

	localparam logic [6:0] MAX_READINGS = 7'd127;

	localparam logic signed [63:0] TEMP_MIN  = -64'sd2621440;
	localparam logic signed [63:0] TEMP_MAX  = 64'sd5570560;
	localparam logic signed [63:0] PRESS_MAX = 64'sd33554431;
	localparam logic signed [47:0] PRESS_OFS = 48'sd262144;

	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = 2;

	typedef struct packed {
		logic        rd;     // carries a reading to accumulate
		logic        fin;    // closes the span
		logic [23:0] raw_t;
		logic [23:0] raw_p;
		logic [6:0]  count;  // readings in span so far (valid with fin)
	} entry_t;

endpackage
`default_nettype wire

// ----- design/bfca_front.sv -----
// bfca_front: FIFO byte parser; classifies frames and emits queue requests.
// Depends on bfca_pkg.
`default_nettype none
module bfca_front #(
	parameter int FIFO_BYTES = 512
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  first_only,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire  [7:0]           fifo_byte,
	input  wire                  last_byte,
	input  wire                  q_full,
	output logic                 q_push,
	output bfca_pkg::entry_t     q_entry
);

	localparam int SpanW = $clog2(FIFO_BYTES + 1);
	localparam logic [SpanW-1:0] SpanMax = SpanW'(FIFO_BYTES);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_TP     = 2'd1;
	localparam logic [1:0] PH_SKIP   = 2'd2;

	logic [1:0]       phase_q, phase_d;
	logic [2:0]       left_q, left_d;
	logic [47:0]      shift_q, shift_d;
	logic [6:0]       seen_q, seen_d, cnt_v;
	logic             stop_q, stop_d;
	logic [SpanW-1:0] span_q, span_d;
	logic             rd_v;
	logic             accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		shift_d = shift_q;
		seen_d  = seen_q;
		stop_d  = stop_q;
		span_d  = span_q;
		rd_v    = 1'b0;
		if (span_q < SpanMax) begin
			span_d = span_q + 1'b1;
			if (phase_q == PH_HEADER) begin
				if (fifo_byte[7:6] == bfca_pkg::HDR_SENSOR) begin
					if (fifo_byte[5:2] == bfca_pkg::FLD_TP) begin
						phase_d = PH_TP;
						left_d  = bfca_pkg::TP_LEN;
					end else if (fifo_byte[5:2] == bfca_pkg::FLD_TIME) begin
						phase_d = PH_SKIP;
						left_d  = bfca_pkg::TIME_LEN;
					end
				end else begin
					phase_d = PH_SKIP;
					left_d  = bfca_pkg::CTRL_LEN;
				end
			end else begin
				if (phase_q == PH_TP)
					shift_d = {fifo_byte, shift_q[47:8]};
				left_d = left_q - 1'b1;
				if (left_q == 3'd1) begin
					phase_d = PH_HEADER;
					if (phase_q == PH_TP && !stop_q && seen_q != bfca_pkg::MAX_READINGS) begin
						rd_v   = 1'b1;
						seen_d = seen_q + 1'b1;
						if (first_only)
							stop_d = 1'b1;
					end
				end
			end
		end
		cnt_v = seen_d;
		// end of span: a frame still open is dropped
		if (last_byte) begin
			phase_d = PH_HEADER;
			left_d  = 3'd0;
			seen_d  = 7'd0;
			stop_d  = 1'b0;
			span_d  = '0;
		end
	end

	always_comb begin
		q_entry.rd    = rd_v;
		q_entry.fin   = last_byte;
		q_entry.raw_t = shift_d[23:0];
		q_entry.raw_p = shift_d[47:24];
		q_entry.count = cnt_v;
		q_push        = accept && (rd_v || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			left_q  <= 3'd0;
			seen_q  <= 7'd0;
			stop_q  <= 1'b0;
			span_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			seen_q  <= seen_d;
			stop_q  <= stop_d;
			span_q  <= span_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			shift_q <= shift_d;
	end

endmodule
`default_nettype wire

// ----- design/bfca_queue.sv -----
// bfca_queue: small request queue between the parser and the compute back end.
// Depends on bfca_pkg.
`default_nettype none
module bfca_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  bfca_pkg::entry_t  wr_entry,
	output logic              full,
	input  wire               pop,
	output bfca_pkg::entry_t  rd_entry,
	output logic              empty
);

	bfca_pkg::entry_t slot_q [bfca_pkg::QueueDepth];
	logic [bfca_pkg::QueuePtrW-1:0] wp_q, rp_q;
	logic [bfca_pkg::QueuePtrW:0]   cnt_q;
	logic do_push, do_pop;

	assign full     = (cnt_q == (bfca_pkg::QueuePtrW+1)'(bfca_pkg::QueueDepth));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= wp_q + 1'b1;
			if (do_pop)
				rp_q <= rp_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wp_q] <= wr_entry;
	end

endmodule
`default_nettype wire

// ----- design/bfca_back.sv -----
// bfca_back: compensation sequencer on one shared multiplier, running sums,
// serial divider for the means, and the result register. Depends on bfca_pkg.
`default_nettype none
module bfca_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  [bfca_pkg::CalW-1:0]    calib,
	input  wire                          q_empty,
	input  bfca_pkg::entry_t             q_head,
	output logic                         q_pop,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic signed [23:0]           mean_temperature,
	output logic [24:0]                  mean_pressure,
	output logic [6:0]                   reading_count,
	output logic                         no_readings
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_ACT    = 3'd2;
	localparam logic [2:0] ST_SUM    = 3'd3;
	localparam logic [2:0] ST_FIN    = 3'd4;
	localparam logic [2:0] ST_DIV    = 3'd5;
	localparam logic [2:0] ST_DIVEND = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	// multiply steps
	localparam logic [4:0] S_DT2  = 5'd0;
	localparam logic [4:0] S_DT3  = 5'd1;
	localparam logic [4:0] S_DD   = 5'd2;
	localparam logic [4:0] S_TT   = 5'd3;
	localparam logic [4:0] S_T2T  = 5'd4;
	localparam logic [4:0] S_P6   = 5'd5;
	localparam logic [4:0] S_P7   = 5'd6;
	localparam logic [4:0] S_P8   = 5'd7;
	localparam logic [4:0] S_P2   = 5'd8;
	localparam logic [4:0] S_P3   = 5'd9;
	localparam logic [4:0] S_P4   = 5'd10;
	localparam logic [4:0] S_KU   = 5'd11;
	localparam logic [4:0] S_UU   = 5'd12;
	localparam logic [4:0] S_P10  = 5'd13;
	localparam logic [4:0] S_WQ   = 5'd14;
	localparam logic [4:0] S_Q11  = 5'd15;
	localparam logic [4:0] S_XU   = 5'd16;

	localparam int DivBits = 33;
	localparam logic [5:0] DivLast = 6'(DivBits - 1);

	// calibration fields
	logic [15:0]        t1, t2c, p5, p6;
	logic signed [7:0]  t3c, p3, p4, p7, p8, p10, p11;
	logic signed [15:0] p1r, p2r, p9;
	logic signed [16:0] p1m, p2m;

	assign t1  = calib[15:0];
	assign t2c = calib[31:16];
	assign t3c = calib[39:32];
	assign p1r = calib[55:40];
	assign p2r = calib[71:56];
	assign p3  = calib[79:72];
	assign p4  = calib[87:80];
	assign p5  = calib[103:88];
	assign p6  = calib[119:104];
	assign p7  = calib[127:120];
	assign p8  = calib[135:128];
	assign p9  = calib[151:136];
	assign p10 = calib[159:152];
	assign p11 = calib[167:160];
	assign p1m = 17'(p1r) - 17'sd16384;
	assign p2m = 17'(p2r) - 17'sd16384;

	logic [2:0]  state_q;
	logic [4:0]  step_q;
	logic        fin_q;
	logic [6:0]  cnt_q;
	logic [23:0] u_q;
	logic signed [24:0] d_q;
	logic signed [63:0] acc_q, prod_q;
	logic signed [35:0] x_q, k_q;
	logic signed [23:0] t_q;
	logic signed [29:0] t2_q;
	logic signed [36:0] t3_q;
	logic [27:0]        qq_q;
	logic signed [32:0] w_q;
	logic signed [47:0] pacc_q;
	logic signed [30:0] tsum_q;
	logic [32:0]        psum_q;

	// divider
	logic [32:0] dvd_q;
	logic [6:0]  rem_q;
	logic [5:0]  dcnt_q;
	logic        dsel_q, tneg_q;
	logic signed [23:0] mt_q;

	logic [7:0] rtry_v;
	logic       ge_v;

	// output register
	logic               ov_q;
	logic signed [23:0] omt_q;
	logic [24:0]        omp_q;
	logic [6:0]         ocnt_q;
	logic               onr_q;
	logic               out_free;

	assign out_valid        = ov_q;
	assign mean_temperature = omt_q;
	assign mean_pressure    = omp_q;
	assign reading_count    = ocnt_q;
	assign no_readings      = onr_q;
	assign out_free         = !ov_q || !out_stall;
	assign q_pop            = (state_q == ST_IDLE) && !q_empty;

	// shared multiplier operand select
	logic signed [36:0] mul_a;
	logic signed [28:0] mul_b;
	logic signed [65:0] mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			S_DT2: begin mul_a = 37'(d_q);  mul_b = 29'($signed({1'b0, t2c})); end
			S_DT3: begin mul_a = 37'(d_q);  mul_b = 29'(t3c); end
			S_DD:  begin mul_a = 37'(x_q);  mul_b = 29'(d_q); end
			S_TT:  begin mul_a = 37'(t_q);  mul_b = 29'(t_q); end
			S_T2T: begin mul_a = 37'(t2_q); mul_b = 29'(t_q); end
			S_P6:  begin mul_a = 37'(t_q);  mul_b = 29'($signed({1'b0, p6})); end
			S_P7:  begin mul_a = 37'(t2_q); mul_b = 29'(p7); end
			S_P8:  begin mul_a = t3_q;      mul_b = 29'(p8); end
			S_P2:  begin mul_a = 37'(t_q);  mul_b = 29'(p2m); end
			S_P3:  begin mul_a = 37'(t2_q); mul_b = 29'(p3); end
			S_P4:  begin mul_a = t3_q;      mul_b = 29'(p4); end
			S_KU:  begin mul_a = 37'(k_q);  mul_b = 29'($signed({1'b0, u_q})); end
			S_UU:  begin mul_a = 37'($signed({1'b0, u_q})); mul_b = 29'($signed({1'b0, u_q})); end
			S_P10: begin mul_a = 37'(t_q);  mul_b = 29'(p10); end
			S_WQ:  begin mul_a = 37'(w_q);  mul_b = 29'($signed({1'b0, qq_q})); end
			S_Q11: begin mul_a = 37'($signed({1'b0, qq_q})); mul_b = 29'(p11); end
			S_XU:  begin mul_a = 37'(x_q);  mul_b = 29'($signed({1'b0, u_q})); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// step results
	logic signed [63:0] sum_v, sh_v, p5_v, p1_v, w_v, tcl_v;
	logic signed [47:0] pfin_v;
	logic [24:0]        pc_v;
	logic signed [24:0] d_v;
	logic [30:0]        tmag_v;

	always_comb begin
		sum_v  = acc_q + prod_q;
		p5_v   = $signed({14'b0, p5, 34'b0});
		p1_v   = $signed({{14{p1m[16]}}, p1m, 33'b0});
		w_v    = $signed({{32{p9[15]}}, p9, 16'b0}) + prod_q;
		sh_v   = sum_v >>> 32;
		if (sh_v < bfca_pkg::TEMP_MIN)
			tcl_v = bfca_pkg::TEMP_MIN;
		else if (sh_v > bfca_pkg::TEMP_MAX)
			tcl_v = bfca_pkg::TEMP_MAX;
		else
			tcl_v = sh_v;
		pfin_v = pacc_q;
		if (pfin_v < 48'sd0)
			pc_v = '0;
		else if (64'(pfin_v) > bfca_pkg::PRESS_MAX)
			pc_v = bfca_pkg::PRESS_MAX[24:0];
		else
			pc_v = pfin_v[24:0];
		d_v    = $signed({1'b0, q_head.raw_t}) - $signed({1'b0, t1, 8'b0});
		tmag_v = 31'(-tsum_q);
		rtry_v = {rem_q, dvd_q[32]};
		ge_v   = (rtry_v >= {1'b0, cnt_q});
	end

	// result valid: set when a result is loaded, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= S_DT2;
			tsum_q  <= '0;
			psum_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						step_q  <= S_DT2;
						state_q <= q_head.rd ? ST_MUL : ST_FIN;
					end
				end
				ST_MUL:  state_q <= ST_ACT;
				ST_ACT: begin
					if (step_q == S_XU) begin
						state_q <= ST_SUM;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_SUM: begin
					tsum_q  <= tsum_q + 31'(t_q);
					psum_q  <= psum_q + 33'(pc_v);
					state_q <= fin_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN:  state_q <= (cnt_q == 7'd0) ? ST_OUT : ST_DIV;
				ST_DIV: begin
					if (dcnt_q == 6'd0)
						state_q <= ST_DIVEND;
				end
				ST_DIVEND: state_q <= dsel_q ? ST_OUT : ST_DIV;
				ST_OUT: begin
					if (out_free) begin
						tsum_q  <= '0;
						psum_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					fin_q <= q_head.fin;
					cnt_q <= q_head.count;
					u_q   <= q_head.raw_p;
					d_q   <= d_v;
				end
			end
			ST_MUL: prod_q <= mul_p[63:0];
			ST_ACT: begin
				case (step_q)
					S_DT2: acc_q  <= prod_q <<< 18;
					S_DT3: x_q    <= prod_q[35:0];
					S_DD:  t_q    <= tcl_v[23:0];
					S_TT:  t2_q   <= prod_q[45:16];
					S_T2T: t3_q   <= prod_q[52:16];
					S_P6:  acc_q  <= p5_v + (prod_q <<< 9);
					S_P7:  acc_q  <= acc_q + (prod_q <<< 7);
					S_P8:  pacc_q <= 48'(sum_v >>> 23);
					S_P2:  acc_q  <= p1_v + (prod_q <<< 8);
					S_P3:  acc_q  <= acc_q + (prod_q <<< 5);
					S_P4:  k_q    <= 36'(sum_v >>> 21);
					S_KU:  pacc_q <= pacc_q + 48'(prod_q >>> 24);
					S_UU:  qq_q   <= prod_q[47:20];
					S_P10: w_q    <= w_v[32:0];
					S_WQ:  pacc_q <= pacc_q + 48'(prod_q >>> 36);
					S_Q11: x_q    <= prod_q[35:0];
					S_XU:  pacc_q <= pacc_q + 48'(prod_q >>> 37) - bfca_pkg::PRESS_OFS;
					default: acc_q <= acc_q;
				endcase
			end
			ST_FIN: begin
				// floor mean of a negative sum: ceil of magnitude, negated
				tneg_q <= tsum_q[30];
				dsel_q <= 1'b0;
				rem_q  <= '0;
				dcnt_q <= DivLast;
				mt_q   <= '0;
				if (tsum_q[30])
					dvd_q <= {2'b0, tmag_v} + {26'b0, cnt_q} - 33'd1;
				else
					dvd_q <= {2'b0, tsum_q};
			end
			ST_DIV: begin
				rem_q  <= ge_v ? 7'(rtry_v - {1'b0, cnt_q}) : rtry_v[6:0];
				dvd_q  <= {dvd_q[31:0], ge_v};
				dcnt_q <= dcnt_q - 1'b1;
			end
			ST_DIVEND: begin
				if (!dsel_q) begin
					mt_q   <= tneg_q ? 24'sd0 - $signed(dvd_q[23:0]) : $signed(dvd_q[23:0]);
					dsel_q <= 1'b1;
					dvd_q  <= psum_q;
					rem_q  <= '0;
					dcnt_q <= DivLast;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					omt_q  <= mt_q;
					omp_q  <= (cnt_q == 7'd0) ? 25'd0 : dvd_q[24:0];
					ocnt_q <= cnt_q;
					onr_q  <= (cnt_q == 7'd0);
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

endmodule
`default_nettype wire

// ----- design/baro_fifo_compensate_average.sv -----
// baro_fifo_compensate_average: top level; configuration registers and the
// parser / queue / compute split. Depends on bfca_pkg, bfca_front, bfca_queue, bfca_back.
//
//  port group   direction  handshake            payload
//  ----------   ---------  -------------------  -----------------------------------------
//  in           to block   in_valid / in_stall  fifo_byte, last_byte
//  out          from block out_valid/out_stall  mean_temperature, mean_pressure,
//                                               reading_count, no_readings
//  apb          to block   psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// Bytes are taken one per cycle while the 4-entry request queue has room.
// A temperature-pressure reading takes the back end through the pop state,
// 17 steps of the shared 37x29 multiplier (multiply, then accumulate) and the summing state.
// End of span adds two 33-bit serial divisions when readings exist.
// Reset clears parser, queue, sums and result valid; calibration resets to zero.
// A stalled result holds the back end in its output state; the queue keeps
// absorbing requests until full, then in_stall rises.
`default_nettype none
module baro_fifo_compensate_average #(
	parameter int FIFO_BYTES = 512
) (
	input  wire                clk,
	input  wire                arst_n,
	// byte requests
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [7:0]         fifo_byte,
	input  wire                last_byte,
	// results
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [23:0] mean_temperature,
	output logic [24:0]        mean_pressure,
	output logic [6:0]         reading_count,
	output logic               no_readings,
	// configuration
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire  [4:0]         paddr,
	input  wire  [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	logic [63:0] cal_low_q, cal_mid_q;
	logic [39:0] cal_high_q;
	logic        first_q;
	logic [1:0]  reg_idx;
	logic        wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_low_q  <= '0;
			cal_mid_q  <= '0;
			cal_high_q <= '0;
			first_q    <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				bfca_pkg::REG_CAL_LOW:  cal_low_q  <= pwdata;
				bfca_pkg::REG_CAL_MID:  cal_mid_q  <= pwdata;
				bfca_pkg::REG_CAL_HIGH: cal_high_q <= pwdata[39:0];
				bfca_pkg::REG_FIRST:    first_q    <= pwdata[0];
				default:                first_q    <= first_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bfca_pkg::REG_CAL_LOW:  prdata = cal_low_q;
			bfca_pkg::REG_CAL_MID:  prdata = cal_mid_q;
			bfca_pkg::REG_CAL_HIGH: prdata = {24'b0, cal_high_q};
			bfca_pkg::REG_FIRST:    prdata = {63'b0, first_q};
			default:                prdata = '0;
		endcase
	end

	// front end -> queue -> back end
	logic             q_full, q_empty, q_push, q_pop;
	bfca_pkg::entry_t q_wr, q_head;

	bfca_front #(
		.FIFO_BYTES(FIFO_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.first_only (first_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.fifo_byte  (fifo_byte),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_wr)
	);

	bfca_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr),
		.full     (q_full),
		.pop      (q_pop),
		.rd_entry (q_head),
		.empty    (q_empty)
	);

	bfca_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.calib            ({cal_high_q, cal_mid_q, cal_low_q}),
		.q_empty          (q_empty),
		.q_head           (q_head),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.mean_temperature (mean_temperature),
		.mean_pressure    (mean_pressure),
		.reading_count    (reading_count),
		.no_readings      (no_readings)
	);

endmodule
`default_nettype wire
